// ----- rtl/sccs_pkg.sv -----
`timescale 1ns / 1ps

package sccs_pkg;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int WORD_W     = 16;
    localparam int CFG_W      = 11;
    localparam int OPC_W      = 5;
    localparam int MEM_ADDR_OUT_W = 5;

    localparam logic [REG_IDX_W-1:0] PC_REG_IDX = REG_IDX_W'(NUM_REGS - 1);

    localparam logic [1:0] OP_EXEC     = 2'd0;
    localparam logic [1:0] OP_LOAD_REG = 2'd1;
    localparam logic [1:0] OP_LOAD_MEM = 2'd2;
    localparam logic [1:0] OP_IDLE     = 2'd3;

    localparam logic [OPC_W-1:0] OPC_ADDI   = 5'h00;
    localparam logic [OPC_W-1:0] OPC_SUBI   = 5'h01;
    localparam logic [OPC_W-1:0] OPC_ADD    = 5'h02;
    localparam logic [OPC_W-1:0] OPC_SUB    = 5'h03;
    localparam logic [OPC_W-1:0] OPC_LH     = 5'h04;
    localparam logic [OPC_W-1:0] OPC_SH     = 5'h05;
    localparam logic [OPC_W-1:0] OPC_SLL    = 5'h06;
    localparam logic [OPC_W-1:0] OPC_SLR    = 5'h07;
    localparam logic [OPC_W-1:0] OPC_OR     = 5'h08;
    localparam logic [OPC_W-1:0] OPC_XOR    = 5'h09;
    localparam logic [OPC_W-1:0] OPC_SLLI   = 5'h0A;
    localparam logic [OPC_W-1:0] OPC_RSVD   = 5'h0B;
    localparam logic [OPC_W-1:0] OPC_SLT    = 5'h0C;
    localparam logic [OPC_W-1:0] OPC_B      = 5'h0D;
    localparam logic [OPC_W-1:0] OPC_BEQ    = 5'h0E;
    localparam logic [OPC_W-1:0] OPC_BGT    = 5'h0F;
    localparam logic [OPC_W-1:0] OPC_BGTZ   = 5'h10;
    localparam logic [OPC_W-1:0] OPC_BGT256 = 5'h11;
    localparam logic [OPC_W-1:0] OPC_RES    = 5'h12;

    localparam logic [WORD_W-1:0] B_REGION_MASK = 16'hF800;
    localparam logic [WORD_W-1:0] B_OFFSET_MASK = 16'h07FF;
    localparam logic [WORD_W-1:0] BGT256_LIMIT  = 16'h0100;

    typedef struct packed {
        logic                 reg_we;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    reg_val;
        logic                 mem_we;
        logic [WORD_W-1:0]    mem_val;
        logic [WORD_W-1:0]    pc_val;
    } sccs_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0]         next_pc;
        logic                      reg_written;
        logic [REG_IDX_W-1:0]      reg_index;
        logic [WORD_W-1:0]         reg_value;
        logic                      mem_written;
        logic [MEM_ADDR_OUT_W-1:0] mem_address;
        logic [WORD_W-1:0]         mem_value;
        logic                      branch_taken;
        logic                      bad_opcode;
        logic                      halted;
    } sccs_res_t;

endpackage

// ----- rtl/sccs_wrap.sv -----
`timescale 1ns / 1ps

module sccs_wrap
    import sccs_pkg::*;
#(
    parameter int DMEM_WORDS = 32
)
(
    input  logic [WORD_W-1:0]             x,
    output logic [$clog2(DMEM_WORDS)-1:0] r
);

    localparam int AW = $clog2(DMEM_WORDS);

    generate
        if ((DMEM_WORDS & (DMEM_WORDS - 1)) == 0) begin : g_pow2
            assign r = x[AW-1:0];
        end else begin : g_recip
            // The reciprocal underestimates the quotient by at most one, so one
            // correction step brings the remainder into range.
            localparam int    SH    = WORD_W + AW;
            localparam int    RW    = SH - AW + 1;
            localparam int    QW    = WORD_W + RW - SH;
            localparam longint RECIP = (64'd1 << SH) / DMEM_WORDS;

            logic [WORD_W+RW-1:0] prod;
            logic [QW-1:0]        quot;
            logic [31:0]          qd;
            logic [WORD_W:0]      rem;
            logic [WORD_W:0]      rem_fix;

            always_comb
            begin
                prod    = (WORD_W + RW)'(x) * (WORD_W + RW)'(RECIP);
                quot    = prod[WORD_W+RW-1:SH];
                qd      = 32'(quot) * 32'(DMEM_WORDS);
                rem     = {1'b0, x} - {1'b0, qd[WORD_W-1:0]};
                rem_fix = (rem >= (WORD_W + 1)'(DMEM_WORDS))
                        ? rem - (WORD_W + 1)'(DMEM_WORDS) : rem;
                r       = rem_fix[AW-1:0];
            end
        end
    endgenerate

endmodule

// ----- rtl/sccs_exec.sv -----
`timescale 1ns / 1ps

module sccs_exec
    import sccs_pkg::*;
#(
    parameter int DMEM_WORDS = 32
)
(
    input  logic [1:0]                    operation,
    input  logic [WORD_W-1:0]             instruction,
    input  logic [4:0]                    load_index,
    input  logic [WORD_W-1:0]             load_value,
    input  logic [CFG_W-1:0]              program_length,
    input  logic [WORD_W-1:0]             pc,
    input  logic [WORD_W-1:0]             rs_val,
    input  logic [WORD_W-1:0]             rt_val,
    input  logic [WORD_W-1:0]             mem_rdata,
    output logic [REG_IDX_W-1:0]          rs_idx,
    output logic [REG_IDX_W-1:0]          rt_idx,
    output logic [$clog2(DMEM_WORDS)-1:0] mem_raddr,
    output logic [$clog2(DMEM_WORDS)-1:0] mem_waddr,
    output sccs_wr_t                      wr,
    output sccs_res_t                     res
);

    localparam int AW = $clog2(DMEM_WORDS);

    logic [OPC_W-1:0]     opc;
    logic [REG_IDX_W-1:0] rd_idx;
    logic [WORD_W-1:0]    imm;
    logic [WORD_W-1:0]    pc2;
    logic [WORD_W-1:0]    end_pc;
    logic [WORD_W-1:0]    ea;
    logic [AW-1:0]        load_addr;
    logic                 halted_now;

    logic                 rw;
    logic [REG_IDX_W-1:0] ridx;
    logic [WORD_W-1:0]    rval;
    logic                 mw;
    logic [AW-1:0]        maddr;
    logic [WORD_W-1:0]    mval;
    logic                 taken;
    logic                 bad;
    logic [WORD_W-1:0]    npc;

    assign opc        = instruction[15:11];
    assign rs_idx     = instruction[10:8];
    assign rt_idx     = instruction[7:5];
    assign rd_idx     = instruction[4:2];
    assign imm        = {{(WORD_W-5){instruction[4]}}, instruction[4:0]};
    assign pc2        = pc + 16'd2;
    assign end_pc     = {4'd0, program_length, 1'b0};
    assign halted_now = (pc >= end_pc);
    assign ea         = rs_val + imm;

    sccs_wrap #(.DMEM_WORDS(DMEM_WORDS)) u_ea_wrap
    (
        .x (ea),
        .r (mem_raddr)
    );

    sccs_wrap #(.DMEM_WORDS(DMEM_WORDS)) u_load_wrap
    (
        .x ({11'd0, load_index}),
        .r (load_addr)
    );

    always_comb
    begin
        rw    = 1'b0;
        ridx  = '0;
        rval  = '0;
        mw    = 1'b0;
        maddr = '0;
        mval  = '0;
        taken = 1'b0;
        bad   = 1'b0;
        npc   = pc;
        unique case (operation)
            OP_LOAD_REG:
            begin
                if (load_index < 5'(PC_REG_IDX))
                begin
                    rw   = 1'b1;
                    ridx = load_index[REG_IDX_W-1:0];
                    rval = load_value;
                end
                else if (load_index == 5'(PC_REG_IDX))
                begin
                    npc  = load_value;
                    rw   = 1'b1;
                    ridx = PC_REG_IDX;
                    rval = load_value;
                end
            end
            OP_LOAD_MEM:
            begin
                mw    = 1'b1;
                maddr = load_addr;
                mval  = load_value;
            end
            OP_EXEC:
            begin
                if (!halted_now)
                begin
                    npc = pc2;
                    unique case (opc)
                        OPC_ADDI:
                        begin
                            rw = 1'b1; ridx = rt_idx; rval = rs_val + imm;
                        end
                        OPC_SUBI:
                        begin
                            rw = 1'b1; ridx = rt_idx; rval = rs_val - imm;
                        end
                        OPC_ADD:
                        begin
                            rw = 1'b1; ridx = rd_idx; rval = rs_val + rt_val;
                        end
                        OPC_SUB:
                        begin
                            rw = 1'b1; ridx = rd_idx; rval = rs_val - rt_val;
                        end
                        OPC_LH:
                        begin
                            rw = 1'b1; ridx = rt_idx; rval = mem_rdata;
                        end
                        OPC_SH:
                        begin
                            mw = 1'b1; maddr = mem_raddr; mval = rt_val;
                        end
                        OPC_SLL:
                        begin
                            rw   = 1'b1;
                            ridx = rd_idx;
                            rval = (|rt_val[15:4]) ? '0 : (rs_val << rt_val[3:0]);
                        end
                        OPC_SLR:
                        begin
                            rw   = 1'b1;
                            ridx = rd_idx;
                            rval = (|rt_val[15:4]) ? '0 : (rs_val >> rt_val[3:0]);
                        end
                        OPC_OR:
                        begin
                            rw = 1'b1; ridx = rd_idx; rval = rs_val | rt_val;
                        end
                        OPC_XOR:
                        begin
                            rw = 1'b1; ridx = rd_idx; rval = rs_val ^ rt_val;
                        end
                        OPC_SLLI:
                        begin
                            rw   = 1'b1;
                            ridx = rt_idx;
                            rval = (|imm[15:4]) ? '0 : (rs_val << imm[3:0]);
                        end
                        OPC_RSVD:
                        begin
                            bad = 1'b0;
                        end
                        OPC_SLT:
                        begin
                            rw   = 1'b1;
                            ridx = rt_idx;
                            rval = {15'd0, ($signed(rs_val) > $signed(rt_val))};
                        end
                        OPC_B:
                        begin
                            taken = 1'b1;
                            npc   = (pc2 & B_REGION_MASK)
                                  | ({instruction[14:0], 1'b0} & B_OFFSET_MASK);
                        end
                        OPC_BEQ:    taken = (rs_val == rt_val);
                        OPC_BGT:    taken = ($signed(rs_val) > $signed(rt_val));
                        OPC_BGTZ:   taken = ($signed(rs_val) > $signed(16'd0));
                        OPC_BGT256: taken = ($signed(rs_val) > $signed(BGT256_LIMIT));
                        OPC_RES:
                        begin
                            rw = 1'b1; ridx = rt_idx; rval = '0;
                        end
                        default:    bad = 1'b1;
                    endcase
                    if (taken && (opc != OPC_B))
                    begin
                        npc = pc2 + {imm[14:0], 1'b0};
                    end
                    // The program counter register takes the next PC instead.
                    if (rw && (ridx == PC_REG_IDX))
                    begin
                        rw   = 1'b0;
                        ridx = '0;
                        rval = '0;
                    end
                end
            end
            OP_IDLE:
            begin
                npc = pc;
            end
            default:
            begin
                npc = pc;
            end
        endcase
    end

    assign mem_waddr = maddr;

    always_comb
    begin
        wr.reg_we  = rw;
        wr.reg_idx = ridx;
        wr.reg_val = rval;
        wr.mem_we  = mw;
        wr.mem_val = mval;
        wr.pc_val  = npc;

        res.next_pc      = npc;
        res.reg_written  = rw;
        res.reg_index    = ridx;
        res.reg_value    = rval;
        res.mem_written  = mw;
        res.mem_address  = MEM_ADDR_OUT_W'(maddr);
        res.mem_value    = mval;
        res.branch_taken = taken;
        res.bad_opcode   = bad;
        res.halted       = (npc >= end_pc);
    end

endmodule

// ----- rtl/sccs_state.sv -----
`timescale 1ns / 1ps

module sccs_state
    import sccs_pkg::*;
#(
    parameter int DMEM_WORDS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  sccs_wr_t                      wr,
    input  logic [$clog2(DMEM_WORDS)-1:0] mem_waddr,
    input  logic [REG_IDX_W-1:0]          rs_idx,
    input  logic [REG_IDX_W-1:0]          rt_idx,
    input  logic [$clog2(DMEM_WORDS)-1:0] mem_raddr,
    output logic [WORD_W-1:0]             pc,
    output logic [WORD_W-1:0]             rs_val,
    output logic [WORD_W-1:0]             rt_val,
    output logic [WORD_W-1:0]             mem_rdata
);

    logic [WORD_W-1:0]     reg_file_reg [NUM_REGS-1];
    logic [WORD_W-1:0]     pc_reg;
    logic [WORD_W-1:0]     dmem_reg     [DMEM_WORDS];
    logic [DMEM_WORDS-1:0] dmem_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            for (int i = 0; i < NUM_REGS - 1; i++)
            begin
                reg_file_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            pc_reg <= wr.pc_val;
            if (wr.reg_we && (wr.reg_idx != PC_REG_IDX))
            begin
                reg_file_reg[wr.reg_idx] <= wr.reg_val;
            end
        end
    end

    // Entries not yet written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmem_valid_reg <= '0;
        end
        else if (commit && wr.mem_we)
        begin
            dmem_valid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && wr.mem_we)
        begin
            dmem_reg[mem_waddr] <= wr.mem_val;
        end
    end

    assign pc        = pc_reg;
    assign rs_val    = (rs_idx == PC_REG_IDX) ? pc_reg : reg_file_reg[rs_idx];
    assign rt_val    = (rt_idx == PC_REG_IDX) ? pc_reg : reg_file_reg[rt_idx];
    assign mem_rdata = dmem_valid_reg[mem_raddr] ? dmem_reg[mem_raddr] : '0;

endmodule

// ----- rtl/single_cycle_16bit_cpu_step.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata, s_tuser (one instruction or preload)
// m_axis    out        m_tvalid/m_tready  m_tdata (step result)
// cfg       in         cfg_wen            cfg_wdata (program length)
//
// One transaction is accepted per cycle into the input register while s_tready is high; once
// that register is full, a stalled output holds s_tready low. It moves into the result register
// when that register is empty or being drained, and its result is presented from there.
// The register file, PC and data memory update when an item leaves the input register.
// Reset clears the registers, the PC, the program length and the memory valid bits.
// A stalled output holds the result; the input register can still take one transaction while
// the result register waits, and both move on as soon as m_tready returns.

module single_cycle_16bit_cpu_step
    import sccs_pkg::*;
#(
    parameter int DMEM_WORDS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // instruction[15:0], load_index[20:16], load_value[36:21], zero[39:37]
    input  logic [39:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0], reg_written[16], reg_index[19:17], reg_value[35:20],
    // mem_written[36], mem_address[41:37], mem_value[57:42], branch_taken[58],
    // bad_opcode[59], halted[60], zero[63:61]
    output logic [63:0] m_tdata,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata
);

    localparam int AW = $clog2(DMEM_WORDS);

    logic                 in_valid_reg;
    logic [1:0]           op_reg;
    logic [WORD_W-1:0]    instr_reg;
    logic [4:0]           lidx_reg;
    logic [WORD_W-1:0]    lval_reg;
    logic [CFG_W-1:0]     prog_len_reg;
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [63:0]          out_data_next;

    logic                 advance;
    logic                 s_accept;
    logic [WORD_W-1:0]    pc;
    logic [WORD_W-1:0]    rs_val;
    logic [WORD_W-1:0]    rt_val;
    logic [WORD_W-1:0]    mem_rdata;
    logic [REG_IDX_W-1:0] rs_idx;
    logic [REG_IDX_W-1:0] rt_idx;
    logic [AW-1:0]        mem_raddr;
    logic [AW-1:0]        mem_waddr;
    sccs_wr_t             wr;
    sccs_res_t            res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= '0;
        end
        else if (cfg_wen)
        begin
            prog_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= s_tuser;
            instr_reg <= s_tdata[15:0];
            lidx_reg  <= s_tdata[20:16];
            lval_reg  <= s_tdata[36:21];
        end
    end

    sccs_state #(.DMEM_WORDS(DMEM_WORDS)) u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (advance),
        .wr        (wr),
        .mem_waddr (mem_waddr),
        .rs_idx    (rs_idx),
        .rt_idx    (rt_idx),
        .mem_raddr (mem_raddr),
        .pc        (pc),
        .rs_val    (rs_val),
        .rt_val    (rt_val),
        .mem_rdata (mem_rdata)
    );

    sccs_exec #(.DMEM_WORDS(DMEM_WORDS)) u_exec
    (
        .operation      (op_reg),
        .instruction    (instr_reg),
        .load_index     (lidx_reg),
        .load_value     (lval_reg),
        .program_length (prog_len_reg),
        .pc             (pc),
        .rs_val         (rs_val),
        .rt_val         (rt_val),
        .mem_rdata      (mem_rdata),
        .rs_idx         (rs_idx),
        .rt_idx         (rt_idx),
        .mem_raddr      (mem_raddr),
        .mem_waddr      (mem_waddr),
        .wr             (wr),
        .res            (res)
    );

    assign out_data_next = {3'd0, res.halted, res.bad_opcode, res.branch_taken,
                            res.mem_value, res.mem_address, res.mem_written,
                            res.reg_value, res.reg_index, res.reg_written,
                            res.next_pc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sccs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_wen;
    logic [10:0] cfg_wdata;

    // Architectural state as the processor should see it.
    logic [15:0] model_regs [0:NUM_REGS-2];
    logic [15:0] model_mem [0:31];
    logic [15:0] model_pc;
    logic [10:0] model_plen;

    sccs_res_t pending_results[$];

    int error_count = 0;
    int results_seen = 0;
    int branches_taken = 0;
    int halted_steps = 0;
    int exec_count = 0;
    int reg_load_count = 0;
    int mem_load_count = 0;
    bit gaps_on = 1;
    bit stalls_on = 1;

    single_cycle_16bit_cpu_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        logic [15:0] corners [0:6];
        corners = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'h0101};
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'($urandom_range(0, 20));
        else if (r < 5)
            return corners[$urandom_range(0, 6)];
        else
            return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_instr();
        logic [4:0] opc;
        if ($urandom_range(0, 9) == 0)
            opc = 5'($urandom_range(19, 31));
        else
            opc = 5'($urandom_range(0, 18));
        return {opc, 11'($urandom)};
    endfunction

    function automatic logic [15:0] instr_i(logic [4:0] opc, logic [2:0] rs, logic [2:0] rt,
                                            logic [4:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [15:0] instr_r(logic [4:0] opc, logic [2:0] rs, logic [2:0] rt,
                                            logic [2:0] rd);
        return {opc, rs, rt, rd, 2'b00};
    endfunction

    function automatic logic is_halted(logic [15:0] p);
        return {1'b0, p} >= {5'b0, model_plen, 1'b0};
    endfunction

    function automatic logic [15:0] read_reg(logic [2:0] idx);
        return (idx == PC_REG_IDX) ? model_pc : model_regs[idx];
    endfunction

    function automatic sccs_res_t step_cpu_model(logic [1:0] op, logic [15:0] instr,
                                                 logic [4:0] lidx, logic [15:0] lval);
        sccs_res_t   r;
        logic [4:0]  opc;
        logic [2:0]  rt;
        logic [2:0]  rd;
        logic [15:0] imm;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] pc2;
        logic [15:0] npc;
        logic        taken;
        r = '0;
        npc = model_pc;
        taken = 1'b0;
        case (op)
            OP_LOAD_REG:
            begin
                if (lidx < PC_REG_IDX)
                begin
                    model_regs[lidx[2:0]] = lval;
                    r.reg_written = 1'b1;
                    r.reg_index = lidx[2:0];
                    r.reg_value = lval;
                end
                else if (lidx == PC_REG_IDX)
                begin
                    model_pc = lval;
                    npc = lval;
                    r.reg_written = 1'b1;
                    r.reg_index = PC_REG_IDX;
                    r.reg_value = lval;
                end
            end
            OP_LOAD_MEM:
            begin
                model_mem[lidx] = lval;
                r.mem_written = 1'b1;
                r.mem_address = lidx;
                r.mem_value = lval;
            end
            OP_EXEC:
            begin
                if (!is_halted(model_pc))
                begin
                    opc = instr[15:11];
                    rt = instr[7:5];
                    rd = instr[4:2];
                    imm = {{11{instr[4]}}, instr[4:0]};
                    a = read_reg(instr[10:8]);
                    b = read_reg(rt);
                    pc2 = model_pc + 16'd2;
                    npc = pc2;
                    case (opc)
                        OPC_ADDI:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = a + imm;
                        end
                        OPC_SUBI:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = a - imm;
                        end
                        OPC_ADD:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a + b;
                        end
                        OPC_SUB:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a - b;
                        end
                        OPC_LH:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = model_mem[a[4:0] + imm[4:0]];
                        end
                        OPC_SH:
                        begin
                            r.mem_written = 1'b1;
                            r.mem_address = a[4:0] + imm[4:0];
                            r.mem_value = b;
                        end
                        OPC_SLL:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a << b;
                        end
                        OPC_SLR:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a >> b;
                        end
                        OPC_OR:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a | b;
                        end
                        OPC_XOR:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rd;
                            r.reg_value = a ^ b;
                        end
                        OPC_SLLI:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = a << imm;
                        end
                        OPC_RSVD:   ;
                        OPC_SLT:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = {15'b0, $signed(a) > $signed(b)};
                        end
                        OPC_B:
                        begin
                            taken = 1'b1;
                            npc = (pc2 & B_REGION_MASK) | ({instr[14:0], 1'b0} & B_OFFSET_MASK);
                        end
                        OPC_BEQ:    taken = (a == b);
                        OPC_BGT:    taken = $signed(a) > $signed(b);
                        OPC_BGTZ:   taken = $signed(a) > 16'sd0;
                        OPC_BGT256: taken = $signed(a) > $signed(BGT256_LIMIT);
                        OPC_RES:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = rt;
                            r.reg_value = '0;
                        end
                        default:    r.bad_opcode = 1'b1;
                    endcase
                    if (taken && opc != OPC_B)
                        npc = pc2 + {imm[14:0], 1'b0};
                    r.branch_taken = taken;
                    // The PC takes the next address, so a write to register 7 is lost.
                    if (r.reg_written && r.reg_index == PC_REG_IDX)
                    begin
                        r.reg_written = 1'b0;
                        r.reg_index = '0;
                        r.reg_value = '0;
                    end
                    if (r.reg_written)
                        model_regs[r.reg_index] = r.reg_value;
                    if (r.mem_written)
                        model_mem[r.mem_address] = r.mem_value;
                    model_pc = npc;
                end
            end
            default: ;
        endcase
        r.next_pc = npc;
        r.halted = is_halted(npc);
        return r;
    endfunction

    task automatic send_step(logic [1:0] op, logic [15:0] instr, logic [4:0] lidx,
                             logic [15:0] lval);
        int gap;
        sccs_res_t expected;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, lval, lidx, instr};
        do
            @(posedge clk);
        while (!s_tready);
        expected = step_cpu_model(op, instr, lidx, lval);
        pending_results = {pending_results, expected};
        case (op)
            OP_EXEC:     exec_count++;
            OP_LOAD_REG: reg_load_count++;
            OP_LOAD_MEM: mem_load_count++;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_program_length(logic [10:0] value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        model_plen = value;
    endtask

    task automatic test_preloads();
        send_step(OP_LOAD_REG, 16'h0000, 5'd1, 16'h7FFF);
        send_step(OP_LOAD_REG, 16'h0000, 5'd2, 16'h8000);
        send_step(OP_LOAD_REG, 16'h0000, 5'd3, 16'h0004);
        send_step(OP_LOAD_REG, 16'hFFFF, 5'd31, 16'hFFFF);
        send_step(OP_LOAD_MEM, 16'h0000, 5'd31, 16'hFFFF);
        send_step(OP_IDLE, 16'hFFFF, 5'd31, 16'hFFFF);
    endtask

    task automatic test_alu_ops();
        send_step(OP_EXEC, instr_i(OPC_ADDI, 3'd1, 3'd4, 5'h10), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_SUBI, 3'd2, 3'd5, 5'h0F), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_ADD, 3'd1, 3'd2, 3'd6), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_SUB, 3'd2, 3'd1, 3'd6), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_SLL, 3'd1, 3'd3, 3'd4), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_SLR, 3'd1, 3'd2, 3'd5), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_OR, 3'd1, 3'd2, 3'd6), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_r(OPC_XOR, 3'd2, 3'd3, 3'd6), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_SLLI, 3'd1, 3'd4, 5'h1F), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_SLT, 3'd1, 3'd2, 5'h00), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_RES, 3'd0, 3'd6, 5'h00), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_ADDI, 3'd0, 3'd7, 5'h05), 5'd0, 16'h0000);
    endtask

    task automatic test_memory_ops();
        send_step(OP_EXEC, instr_i(OPC_SH, 3'd0, 3'd1, 5'h1F), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_LH, 3'd0, 3'd4, 5'h1F), 5'd0, 16'h0000);
    endtask

    task automatic test_branches();
        send_step(OP_EXEC, instr_i(OPC_BEQ, 3'd0, 3'd0, 5'h03), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_BGT, 3'd2, 3'd1, 5'h10), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_BGTZ, 3'd1, 3'd0, 5'h10), 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_BGT256, 3'd3, 3'd0, 5'h02), 5'd0, 16'h0000);
        send_step(OP_EXEC, {OPC_B, 11'h7FF}, 5'd0, 16'h0000);
        send_step(OP_EXEC, instr_i(OPC_RSVD, 3'd1, 3'd2, 5'h1F), 5'd0, 16'h0000);
        send_step(OP_EXEC, 16'hFFFF, 5'd0, 16'h0000);
    endtask

    task automatic test_halt_and_idle();
        send_step(OP_LOAD_REG, 16'h0000, 5'd7, 16'h0800);
        send_step(OP_EXEC, instr_i(OPC_ADDI, 3'd1, 3'd1, 5'h01), 5'd0, 16'h0000);
        send_step(OP_LOAD_REG, 16'h0000, 5'd7, 16'h0000);
    endtask

    task automatic test_random(int count, logic [10:0] plen);
        int r;
        drain_results();
        set_program_length(plen);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (i == count / 2)
                drain_results();
            r = $urandom_range(0, 99);
            // Keep the program counter inside the program most of the time.
            if (is_halted(model_pc) && plen != 0 && $urandom_range(0, 2) != 0)
                send_step(OP_LOAD_REG, 16'($urandom), 5'd7,
                          16'(2 * $urandom_range(0, plen - 1)));
            else if (r < 65)
                send_step(OP_EXEC, pick_instr(), 5'($urandom), 16'($urandom));
            else if (r < 80)
                send_step(OP_LOAD_REG, 16'($urandom),
                          ($urandom_range(0, 7) == 0) ? 5'($urandom)
                                                      : 5'($urandom_range(0, 6)),
                          pick_word());
            else if (r < 94)
                send_step(OP_LOAD_MEM, 16'($urandom), 5'($urandom), pick_word());
            else if (r < 97)
                send_step(OP_IDLE, 16'($urandom), 5'($urandom), 16'($urandom));
            else
                send_step(OP_LOAD_REG, 16'($urandom), 5'd7, 16'($urandom));
        end
    endtask

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        sccs_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result transaction arrived with none outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                branches_taken += want.branch_taken;
                halted_steps += want.halted;
                compare_field("next_pc", want.next_pc, m_tdata[15:0]);
                compare_field("reg_written", 16'(want.reg_written), 16'(m_tdata[16]));
                compare_field("reg_index", 16'(want.reg_index), 16'(m_tdata[19:17]));
                compare_field("reg_value", want.reg_value, m_tdata[35:20]);
                compare_field("mem_written", 16'(want.mem_written), 16'(m_tdata[36]));
                compare_field("mem_address", 16'(want.mem_address), 16'(m_tdata[41:37]));
                compare_field("mem_value", want.mem_value, m_tdata[57:42]);
                compare_field("branch_taken", 16'(want.branch_taken), 16'(m_tdata[58]));
                compare_field("bad_opcode", 16'(want.bad_opcode), 16'(m_tdata[59]));
                compare_field("halted", 16'(want.halted), 16'(m_tdata[60]));
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (stalls_on)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_IDLE;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        model_pc = '0;
        model_plen = '0;
        foreach (model_regs[i])
            model_regs[i] = '0;
        foreach (model_mem[i])
            model_mem[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_program_length(11'd1024);
        test_preloads();
        test_alu_ops();
        test_memory_ops();
        test_branches();
        test_halt_and_idle();
        test_random(500, 11'd1024);
        test_random(300, 11'($urandom_range(2, 64)));
        test_random(150, 11'd0);
        test_random(150, 11'd1);
        test_random(300, 11'($urandom_range(0, 1024)));
        drain_results();
        repeat (10) @(posedge clk);
        $display("Checked %0d result transactions from %0d executes, %0d register loads and",
                 results_seen, exec_count, reg_load_count);
        $display("%0d memory loads; %0d branches were taken and %0d steps ended halted.",
                 mem_load_count, branches_taken, halted_steps);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- single_cycle_16bit_cpu_step.f -----
rtl/sccs_pkg.sv
rtl/sccs_wrap.sv
rtl/sccs_exec.sv
rtl/sccs_state.sv
rtl/single_cycle_16bit_cpu_step.sv
test/testbench.sv
